@@ design/mqmb_pkg.sv @@
package mqmb_pkg;

    localparam int unsigned DEF_QUEUES     = 16;
    localparam int unsigned DEF_RING_SLOTS = 8;
    localparam int unsigned DEF_MSG_BYTES  = 16;

    localparam int unsigned QUEUE_W  = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 5;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_EMPTY      = 3'd1,
        STATUS_FULL       = 3'd2,
        STATUS_BAD_QUEUE  = 3'd3,
        STATUS_BAD_LENGTH = 3'd4
    } status_t;

    typedef enum logic {
        OP_SEND    = 1'b0,
        OP_RECEIVE = 1'b1
    } op_t;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data_out;
        status_t           status;
    } result_t;

endpackage

@@ design/mqmb_slot_store.sv @@
module mqmb_slot_store #(
    parameter int unsigned QUEUES     = mqmb_pkg::DEF_QUEUES,
    parameter int unsigned RING_SLOTS = mqmb_pkg::DEF_RING_SLOTS,
    parameter int unsigned MSG_BYTES  = mqmb_pkg::DEF_MSG_BYTES,
    parameter int unsigned QIW        = (QUEUES > 1) ? $clog2(QUEUES) : 1,
    parameter int unsigned PW         = $clog2(RING_SLOTS),
    parameter int unsigned BW         = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1,
    parameter int unsigned CW         = $clog2(MSG_BYTES + 1)
) (
    input  logic                          aclk,
    input  logic                          byte_wr_en,
    input  logic [QIW-1:0]                byte_wr_queue,
    input  logic [PW-1:0]                 byte_wr_slot,
    input  logic [BW-1:0]                 byte_wr_index,
    input  logic [mqmb_pkg::BYTE_W-1:0]   byte_wr_data,
    input  logic                          byte_rd_en,
    input  logic [QIW-1:0]                byte_rd_queue,
    input  logic [PW-1:0]                 byte_rd_slot,
    input  logic [BW-1:0]                 byte_rd_index,
    output logic [mqmb_pkg::BYTE_W-1:0]   byte_rd_data,
    input  logic                          len_wr_en,
    input  logic [QIW-1:0]                len_wr_queue,
    input  logic [PW-1:0]                 len_wr_slot,
    input  logic [CW-1:0]                 len_wr_data,
    input  logic                          len_rd_en,
    input  logic [QIW-1:0]                len_rd_queue,
    input  logic [PW-1:0]                 len_rd_slot,
    output logic [CW-1:0]                 len_rd_data
);
    import mqmb_pkg::*;

    logic [BYTE_W-1:0] byte_mem [QUEUES][RING_SLOTS][MSG_BYTES];
    logic [CW-1:0]     len_mem  [QUEUES][RING_SLOTS];

    always_ff @(posedge aclk) begin
        if (byte_wr_en) begin
            byte_mem[byte_wr_queue][byte_wr_slot][byte_wr_index] <= byte_wr_data;
        end
        if (byte_rd_en) begin
            byte_rd_data <= byte_mem[byte_rd_queue][byte_rd_slot][byte_rd_index];
        end
    end

    always_ff @(posedge aclk) begin
        if (len_wr_en) begin
            len_mem[len_wr_queue][len_wr_slot] <= len_wr_data;
        end
        if (len_rd_en) begin
            len_rd_data <= len_mem[len_rd_queue][len_rd_slot];
        end
    end

endmodule

@@ design/multi_queue_message_mailbox_top.sv @@
// Mailbox with one message ring per queue. A send streams one byte per cycle while s_tready
// is high, into the tail slot of its queue (queue taken from the first byte); the byte
// marked tlast commits the message and returns one status response in the next cycle.
// A receive reads the slot length from the length memory, then streams the message from
// the byte memory one byte per cycle while m_tready allows; its first byte passes S_LEN,
// a byte-memory read and the output register. No new request is taken until the final
// byte of a receive sits in the output register. Errors and empty rings give one response.
// Message storage is never cleared: slots are only read after a committed send wrote them.
module multi_queue_message_mailbox_top #(
    parameter int unsigned QUEUES     = mqmb_pkg::DEF_QUEUES,
    parameter int unsigned RING_SLOTS = mqmb_pkg::DEF_RING_SLOTS,
    parameter int unsigned MSG_BYTES  = mqmb_pkg::DEF_MSG_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mqmb_pkg::S_DATA_W-1:0] s_tdata,   // queue[3:0], data[11:4], zero pad
    input  logic                          s_tuser,   // operation
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mqmb_pkg::M_DATA_W-1:0] m_tdata,   // status[2:0], data_out[10:3], length[15:11]
    output logic                          m_tlast    // last
);
    import mqmb_pkg::*;

    localparam int unsigned QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int unsigned PW  = $clog2(RING_SLOTS);
    localparam int unsigned BW  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int unsigned CW  = $clog2(MSG_BYTES + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LEN    = 3'b010,
        S_STREAM = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [PW-1:0]      head_reg [QUEUES];
    logic [PW-1:0]      tail_reg [QUEUES];
    logic [CW-1:0]      acnt_reg, acnt_next;
    logic [QUEUE_W-1:0] aq_reg, aq_next;
    status_t            aerr_reg, aerr_next;
    logic [QIW-1:0]     rq_reg, rq_next;
    logic [PW-1:0]      rslot_reg, rslot_next;
    logic [CW-1:0]      rlen_reg, rlen_next;
    logic [CW-1:0]      ridx_reg, ridx_next;
    logic [CW-1:0]      lcnt_reg, lcnt_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               out_last_reg, out_last_next;

    op_t                in_op;
    logic [QUEUE_W-1:0] in_queue;
    logic [BYTE_W-1:0]  in_data;
    logic               out_free;
    logic               accept;

    logic               snd_first;
    logic [QUEUE_W-1:0] snd_q;
    logic [QIW-1:0]     snd_qi;
    status_t            snd_err;
    status_t            snd_err_new;
    logic               snd_room;
    logic [CW-1:0]      snd_cnt;
    logic [PW-1:0]      snd_tail;
    logic [PW-1:0]      snd_nx;
    logic               snd_full;

    logic [QIW-1:0]     rcv_qi;
    logic               rcv_qok;
    logic [PW-1:0]      rcv_head;
    logic [PW-1:0]      rcv_nx;
    logic               rcv_empty;

    logic               byte_wr_en;
    logic               len_wr_en;
    logic               len_rd_en;
    logic               byte_rd_en;
    logic [BYTE_W-1:0]  byte_rd_data;
    logic [CW-1:0]      len_rd_data;
    logic               str_load;
    logic               str_last;

    assign in_op    = op_t'(s_tuser);
    assign in_queue = s_tdata[QUEUE_W-1:0];
    assign in_data  = s_tdata[QUEUE_W+BYTE_W-1:QUEUE_W];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign snd_first   = (acnt_reg == '0);
    assign snd_q       = snd_first ? in_queue : aq_reg;
    assign snd_qi      = QIW'(snd_q);
    assign snd_err     = snd_first ? ((32'(in_queue) < QUEUES) ? STATUS_OK : STATUS_BAD_QUEUE)
                                   : aerr_reg;
    assign snd_room    = 32'(acnt_reg) < MSG_BYTES;
    assign snd_cnt     = snd_room ? CW'(acnt_reg + 1'b1) : acnt_reg;
    assign snd_err_new = (!snd_room && snd_err == STATUS_OK) ? STATUS_BAD_LENGTH : snd_err;
    assign snd_tail    = tail_reg[snd_qi];
    assign snd_nx      = (snd_tail == PW'(RING_SLOTS - 1)) ? '0 : PW'(snd_tail + 1'b1);
    assign snd_full    = (snd_nx == head_reg[snd_qi]);

    assign rcv_qi    = QIW'(in_queue);
    assign rcv_qok   = 32'(in_queue) < QUEUES;
    assign rcv_head  = head_reg[rcv_qi];
    assign rcv_nx    = (rcv_head == PW'(RING_SLOTS - 1)) ? '0 : PW'(rcv_head + 1'b1);
    assign rcv_empty = (rcv_head == tail_reg[rcv_qi]);

    assign byte_wr_en = accept && in_op == OP_SEND && snd_room && snd_err != STATUS_BAD_QUEUE;
    assign len_wr_en  = accept && in_op == OP_SEND && s_tlast && snd_err_new == STATUS_OK
                        && !snd_full;
    assign len_rd_en  = accept && in_op == OP_RECEIVE && rcv_qok && !rcv_empty;

    assign str_load   = (state_reg == S_STREAM) && pend_reg && out_free;
    assign str_last   = (CW'(lcnt_reg + 1'b1) == rlen_reg);
    assign byte_rd_en = (state_reg == S_STREAM) && (ridx_reg != rlen_reg)
                        && (!pend_reg || str_load);

    mqmb_slot_store #(
        .QUEUES     (QUEUES),
        .RING_SLOTS (RING_SLOTS),
        .MSG_BYTES  (MSG_BYTES),
        .QIW        (QIW),
        .PW         (PW),
        .BW         (BW),
        .CW         (CW)
    ) u_store (
        .aclk          (aclk),
        .byte_wr_en    (byte_wr_en),
        .byte_wr_queue (snd_qi),
        .byte_wr_slot  (snd_tail),
        .byte_wr_index (acnt_reg[BW-1:0]),
        .byte_wr_data  (in_data),
        .byte_rd_en    (byte_rd_en),
        .byte_rd_queue (rq_reg),
        .byte_rd_slot  (rslot_reg),
        .byte_rd_index (ridx_reg[BW-1:0]),
        .byte_rd_data  (byte_rd_data),
        .len_wr_en     (len_wr_en),
        .len_wr_queue  (snd_qi),
        .len_wr_slot   (snd_tail),
        .len_wr_data   (snd_cnt),
        .len_rd_en     (len_rd_en),
        .len_rd_queue  (rcv_qi),
        .len_rd_slot   (rcv_head),
        .len_rd_data   (len_rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        acnt_next      = acnt_reg;
        aq_next        = aq_reg;
        aerr_next      = aerr_reg;
        rq_next        = rq_reg;
        rslot_next     = rslot_reg;
        rlen_next      = rlen_reg;
        ridx_next      = ridx_reg;
        lcnt_next      = lcnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_SEND) begin
                        if (s_tlast) begin
                            out_valid_next    = 1'b1;
                            out_last_next     = 1'b1;
                            out_next.data_out = '0;
                            out_next.length   = '0;
                            if (snd_err_new != STATUS_OK) begin
                                out_next.status = snd_err_new;
                            end else if (snd_full) begin
                                out_next.status = STATUS_FULL;
                            end else begin
                                out_next.status = STATUS_OK;
                                out_next.length = LEN_W'(snd_cnt);
                            end
                            acnt_next = '0;
                            aq_next   = '0;
                            aerr_next = STATUS_OK;
                        end else begin
                            acnt_next = snd_cnt;
                            aq_next   = snd_q;
                            aerr_next = snd_err_new;
                        end
                    end else if (!rcv_qok || rcv_empty) begin
                        out_valid_next    = 1'b1;
                        out_last_next     = 1'b1;
                        out_next.data_out = '0;
                        out_next.length   = '0;
                        out_next.status   = rcv_qok ? STATUS_EMPTY : STATUS_BAD_QUEUE;
                    end else begin
                        rq_next    = rcv_qi;
                        rslot_next = rcv_head;
                        state_next = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (len_rd_data == '0) begin
                    if (out_free) begin
                        out_valid_next    = 1'b1;
                        out_last_next     = 1'b1;
                        out_next.data_out = '0;
                        out_next.length   = '0;
                        out_next.status   = STATUS_EMPTY;
                        state_next        = S_IDLE;
                    end
                end else begin
                    rlen_next  = len_rd_data;
                    ridx_next  = '0;
                    lcnt_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_STREAM;
                end
            end
            S_STREAM: begin
                if (byte_rd_en) begin
                    ridx_next = CW'(ridx_reg + 1'b1);
                end
                pend_next = byte_rd_en || (pend_reg && !str_load);
                if (str_load) begin
                    out_valid_next    = 1'b1;
                    out_last_next     = str_last;
                    out_next.status   = STATUS_OK;
                    out_next.data_out = byte_rd_data;
                    out_next.length   = LEN_W'(rlen_reg);
                    lcnt_next         = CW'(lcnt_reg + 1'b1);
                    if (str_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUES; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            if (len_wr_en) begin
                tail_reg[snd_qi] <= snd_nx;
            end
            if (len_rd_en) begin
                head_reg[rcv_qi] <= rcv_nx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            acnt_reg      <= '0;
            aq_reg        <= '0;
            aerr_reg      <= STATUS_OK;
            ridx_reg      <= '0;
            lcnt_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acnt_reg      <= acnt_next;
            aq_reg        <= aq_next;
            aerr_reg      <= aerr_next;
            ridx_reg      <= ridx_next;
            lcnt_reg      <= lcnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rq_reg       <= rq_next;
        rslot_reg    <= rslot_next;
        rlen_reg     <= rlen_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_reg);
    assign m_tlast  = out_last_reg;

endmodule
